### rtl/aags_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aags_pkg
// Shared types, constants and character decode for the affine gap scorer.
// ----------------------------------------------------------------------------
package aags_pkg;

	localparam int ALPHA_SIZE_DEF = 16;

	localparam int LETTER_W = 4;
	localparam int CHAR_W   = 8;
	localparam int ENTRY_W  = 16;
	localparam int SCORE_W  = 32;
	localparam int COUNT_W  = 16;
	localparam int OPEN_W   = 11;
	localparam int EXT_W    = 9;
	localparam int P_OPEN_W = COUNT_W + OPEN_W;
	localparam int P_EXT_W  = COUNT_W + EXT_W;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = OPEN_W;

	localparam logic [CFG_IDX_W-1:0] REG_OPEN_PENALTY   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_EXTEND_PENALTY = CFG_IDX_W'(1);

	localparam logic [OPEN_W-1:0] OPEN_PENALTY_RST = OPEN_W'(256);
	localparam logic [EXT_W-1:0]  EXT_PENALTY_RST  = EXT_W'(26);

	localparam logic OP_SCORE = 1'b0;
	localparam logic OP_LOAD  = 1'b1;

	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CHAR_DASH    = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_DOT     = 8'h2E;

	typedef struct packed {
		logic                       operation;
		logic [CHAR_W-1:0]          q_char;
		logic [CHAR_W-1:0]          r_char;
		logic [LETTER_W-1:0]        q_letter;
		logic [LETTER_W-1:0]        r_letter;
		logic signed [ENTRY_W-1:0]  entry_value;
		logic                       last_column;
	} in_item_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0]  total_score;
		logic signed [SCORE_W-1:0]  subst_score;
		logic [COUNT_W-1:0]         open_count;
		logic [COUNT_W-1:0]         extend_count;
		logic                       double_gap_error;
	} out_item_t;

	// per-column decode carried with the table read
	typedef struct packed {
		logic upper_ok;
		logic q_gap;
		logic r_gap;
		logic last;
	} col_flags_t;

	// alignment totals at its last column
	typedef struct packed {
		logic signed [SCORE_W-1:0] sum;
		logic [COUNT_W-1:0]        opens;
		logic [COUNT_W-1:0]        exts;
		logic                      err;
	} snap_t;

	function automatic logic is_upper(input logic [CHAR_W-1:0] c);
		return c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]};
	endfunction

	function automatic logic is_gap(input logic [CHAR_W-1:0] c);
		return c inside {CHAR_DASH, CHAR_DOT};
	endfunction

endpackage

### rtl/aags_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aags_table
// Score table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module aags_table #(
	parameter int ALPHA_SIZE = aags_pkg::ALPHA_SIZE_DEF,
	parameter int DEPTH      = ALPHA_SIZE * ALPHA_SIZE,
	parameter int ADDR_W     = $clog2(DEPTH)
) (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  logic [ADDR_W-1:0]                    wr_addr,
	input  logic signed [aags_pkg::ENTRY_W-1:0]  wr_data,
	input  logic                                 rd_en,
	input  logic [ADDR_W-1:0]                    rd_addr,
	output logic signed [aags_pkg::ENTRY_W-1:0]  rd_data_s1
);

	logic signed [aags_pkg::ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

endmodule

### rtl/aags_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aags_accum
// Column stage and per-alignment accumulators; snapshots totals on the last
// column and clears for the next alignment.
// ----------------------------------------------------------------------------
module aags_accum (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 col_load,
	input  aags_pkg::col_flags_t                 col_flags,
	input  logic signed [aags_pkg::ENTRY_W-1:0]  entry_s1,
	output logic                                 col_free,
	output logic                                 snap_valid,
	input  logic                                 snap_ready,
	output aags_pkg::snap_t                      snap
);

	logic                               valid_s1;
	aags_pkg::col_flags_t               flags_s1;
	logic signed [aags_pkg::SCORE_W-1:0] sum_q;
	logic [aags_pkg::COUNT_W-1:0]       opens_q;
	logic [aags_pkg::COUNT_W-1:0]       extends_q;
	logic                               in_gap_q;
	logic                               err_q;
	logic                               snap_valid_q;
	aags_pkg::snap_t                    snap_q;

	logic                               snap_free;
	logic                               adv_s1;
	logic signed [aags_pkg::SCORE_W:0]  sum_wide;
	logic                               gap;
	aags_pkg::snap_t                    nxt;

	assign snap_free = !snap_valid_q || snap_ready;
	assign adv_s1    = valid_s1 && (!flags_s1.last || snap_free);
	assign col_free  = !valid_s1 || adv_s1;

	assign sum_wide = {sum_q[aags_pkg::SCORE_W-1], sum_q}
		+ (aags_pkg::SCORE_W+1)'(entry_s1);
	assign gap = flags_s1.q_gap || flags_s1.r_gap;

	always_comb begin
		nxt = '{sum: sum_q, opens: opens_q, exts: extends_q, err: err_q};
		if (flags_s1.upper_ok) begin
			if (sum_wide[aags_pkg::SCORE_W] != sum_wide[aags_pkg::SCORE_W-1]) begin
				nxt.sum = sum_wide[aags_pkg::SCORE_W]
					? {1'b1, {(aags_pkg::SCORE_W-1){1'b0}}}
					: {1'b0, {(aags_pkg::SCORE_W-1){1'b1}}};
			end else begin
				nxt.sum = sum_wide[aags_pkg::SCORE_W-1:0];
			end
		end
		if (gap && !in_gap_q && opens_q != '1) begin
			nxt.opens = opens_q + aags_pkg::COUNT_W'(1);
		end
		if (gap && in_gap_q && extends_q != '1) begin
			nxt.exts = extends_q + aags_pkg::COUNT_W'(1);
		end
		if (flags_s1.q_gap && flags_s1.r_gap) begin
			nxt.err = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			flags_s1     <= '0;
			sum_q        <= '0;
			opens_q      <= '0;
			extends_q    <= '0;
			in_gap_q     <= 1'b0;
			err_q        <= 1'b0;
			snap_valid_q <= 1'b0;
		end else begin
			if (col_free) begin
				valid_s1 <= col_load;
			end
			if (col_load) begin
				flags_s1 <= col_flags;
			end
			if (adv_s1 && flags_s1.last) begin
				sum_q        <= '0;
				opens_q      <= '0;
				extends_q    <= '0;
				in_gap_q     <= 1'b0;
				err_q        <= 1'b0;
				snap_valid_q <= 1'b1;
			end else begin
				if (adv_s1) begin
					sum_q     <= nxt.sum;
					opens_q   <= nxt.opens;
					extends_q <= nxt.exts;
					in_gap_q  <= gap;
					err_q     <= nxt.err;
				end
				if (snap_ready) begin
					snap_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && flags_s1.last) begin
			snap_q <= nxt;
		end
	end

	assign snap_valid = snap_valid_q;
	assign snap       = snap_q;

endmodule

### rtl/aags_result.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aags_result
// Gap penalty products, saturating total and the output register.
// ----------------------------------------------------------------------------
module aags_result (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [aags_pkg::OPEN_W-1:0]        open_penalty,
	input  logic [aags_pkg::EXT_W-1:0]         extend_penalty,
	input  logic                               snap_valid,
	output logic                               snap_ready,
	input  aags_pkg::snap_t                    snap,
	output logic                               out_valid,
	input  logic                               out_ready,
	output aags_pkg::out_item_t                out_data
);

	localparam int TOT_W = aags_pkg::SCORE_W + 2;

	logic                               valid_s3;
	aags_pkg::snap_t                    snap_s3;
	logic [aags_pkg::P_OPEN_W-1:0]      p_open_s3;
	logic [aags_pkg::P_EXT_W-1:0]       p_ext_s3;
	logic                               out_valid_q;
	aags_pkg::out_item_t                out_q;

	logic                               out_free;
	logic                               s3_free;
	logic signed [TOT_W-1:0]            total;
	logic signed [aags_pkg::SCORE_W-1:0] total_sat;

	assign out_free   = !out_valid_q || out_ready;
	assign s3_free    = !valid_s3 || out_free;
	assign snap_ready = s3_free;

	assign total = TOT_W'(snap_s3.sum) - TOT_W'(p_open_s3) - TOT_W'(p_ext_s3);

	always_comb begin
		if (total[TOT_W-1:aags_pkg::SCORE_W-1] == '0
				|| total[TOT_W-1:aags_pkg::SCORE_W-1] == '1) begin
			total_sat = total[aags_pkg::SCORE_W-1:0];
		end else if (total[TOT_W-1]) begin
			total_sat = {1'b1, {(aags_pkg::SCORE_W-1){1'b0}}};
		end else begin
			total_sat = {1'b0, {(aags_pkg::SCORE_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s3_free) begin
				valid_s3 <= snap_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && snap_valid) begin
			snap_s3   <= snap;
			p_open_s3 <= aags_pkg::P_OPEN_W'(snap.opens) * aags_pkg::P_OPEN_W'(open_penalty);
			p_ext_s3  <= aags_pkg::P_EXT_W'(snap.exts) * aags_pkg::P_EXT_W'(extend_penalty);
		end
		if (out_free && valid_s3) begin
			out_q.total_score      <= total_sat;
			out_q.subst_score      <= snap_s3.sum;
			out_q.open_count       <= snap_s3.opens;
			out_q.extend_count     <= snap_s3.exts;
			out_q.double_gap_error <= snap_s3.err;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### rtl/alignment_affine_gap_scorer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alignment_affine_gap_scorer
// Streams alignment columns, sums table scores and gap costs, Q24.8 result.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one column or one table load per transfer; operation selects.
//            A load writes the score table at the transfer edge.
//   out_*  : one result per alignment, after the column with last_column set.
//   cfg_*  : penalty registers, always ready; write only while idle.
// Throughput: one input transfer per cycle while in_ready is high, set by the single
//   table read port and the one-column accumulate stage.
// Result path: after the last column's transfer come, in order, the stages
//   table read, accumulate/snapshot, penalty products, output register.
// Reset: penalties return to 256 and 26, counts, sum, gap state and error
//   clear; score table contents are undefined until loaded.
// Stall: with out_ready low the full stages hold; in_ready falls only once the
//   snapshot, product and output stages are all full and a last column waits.
// ----------------------------------------------------------------------------
module alignment_affine_gap_scorer #(
	parameter int ALPHA_SIZE = aags_pkg::ALPHA_SIZE_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  aags_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output aags_pkg::out_item_t                  out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [aags_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [aags_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int DEPTH  = ALPHA_SIZE * ALPHA_SIZE;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [aags_pkg::OPEN_W-1:0]  open_penalty_q;
	logic [aags_pkg::EXT_W-1:0]   extend_penalty_q;

	logic                          in_xfer;
	logic                          letters_ok;
	logic [ADDR_W-1:0]             addr;
	logic                          load_wr;
	logic                          col_load;
	logic                          col_free;
	aags_pkg::col_flags_t          col_flags;
	logic signed [aags_pkg::ENTRY_W-1:0] entry_s1;
	logic                          snap_valid;
	logic                          snap_ready;
	aags_pkg::snap_t               snap;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_penalty_q   <= aags_pkg::OPEN_PENALTY_RST;
			extend_penalty_q <= aags_pkg::EXT_PENALTY_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				aags_pkg::REG_OPEN_PENALTY: begin
					open_penalty_q <= cfg_data;
				end
				aags_pkg::REG_EXTEND_PENALTY: begin
					extend_penalty_q <= cfg_data[aags_pkg::EXT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign in_ready   = col_free;
	assign in_xfer    = in_valid && in_ready;
	assign letters_ok = int'(in_data.q_letter) < ALPHA_SIZE
		&& int'(in_data.r_letter) < ALPHA_SIZE;
	assign addr = ADDR_W'(int'(in_data.q_letter) * ALPHA_SIZE + int'(in_data.r_letter));
	assign load_wr  = in_xfer && in_data.operation == aags_pkg::OP_LOAD && letters_ok;
	assign col_load = in_xfer && in_data.operation == aags_pkg::OP_SCORE;

	assign col_flags.upper_ok = aags_pkg::is_upper(in_data.q_char)
		&& aags_pkg::is_upper(in_data.r_char) && letters_ok;
	assign col_flags.q_gap = aags_pkg::is_gap(in_data.q_char);
	assign col_flags.r_gap = aags_pkg::is_gap(in_data.r_char);
	assign col_flags.last  = in_data.last_column;

	aags_table #(
		.ALPHA_SIZE (ALPHA_SIZE)
	) u_table (
		.clk        (clk),
		.wr_en      (load_wr),
		.wr_addr    (addr),
		.wr_data    (in_data.entry_value),
		.rd_en      (col_load),
		.rd_addr    (addr),
		.rd_data_s1 (entry_s1)
	);

	aags_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.col_load   (col_load),
		.col_flags  (col_flags),
		.entry_s1   (entry_s1),
		.col_free   (col_free),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap)
	);

	aags_result u_result (
		.clk            (clk),
		.arst_n         (arst_n),
		.open_penalty   (open_penalty_q),
		.extend_penalty (extend_penalty_q),
		.snap_valid     (snap_valid),
		.snap_ready     (snap_ready),
		.snap           (snap),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data)
	);

`ifndef ASSERT_OFF
	// penalties are never negative, so they cannot raise the total
	a_total_le_subst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.total_score <= out_data.subst_score)
		else $error("total above substitution sum");

	// an extension always follows an open within the same alignment
	a_ext_needs_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.open_count == '0 |-> out_data.extend_count == '0)
		else $error("extensions without any open");

	// a double gap column is itself a gap column
	a_dgap_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.double_gap_error |-> out_data.open_count != '0)
		else $error("double gap with no gap counted");

	// the pipeline drains: an unstalled output means the input side is free
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !snap_valid |-> in_ready)
		else $error("input stalled with empty downstream");
`endif

endmodule
